>>> rtl/lant_pkg.sv
package lant_pkg;

  // Grid and color limits
  localparam int MAX_SIDE   = 1024;
  localparam int MAX_COLORS = 30;
  localparam int SIDE_W     = $clog2(MAX_SIDE);
  localparam int ADDR_W     = 2 * SIDE_W;
  localparam int MEM_DEPTH  = MAX_SIDE * MAX_SIDE;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int READ_W     = 10;
  localparam int COORD_W    = 11;
  localparam int HEAD_W     = 2;
  localparam int COLOR_W    = 5;
  localparam int COUNT_W    = 48;
  localparam int CCOUNT_W   = 5;
  localparam int RULE_W     = 30;
  localparam int SIDE_CFG_W = 11;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_STEP    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  // Heading codes
  localparam logic [HEAD_W-1:0] HEAD_NORTH = 2'd0;
  localparam logic [HEAD_W-1:0] HEAD_EAST  = 2'd1;
  localparam logic [HEAD_W-1:0] HEAD_SOUTH = 2'd2;
  localparam logic [HEAD_W-1:0] HEAD_WEST  = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_COLOR_COUNT = 2'd0;
  localparam logic [1:0] REG_TURN_RULES  = 2'd1;
  localparam logic [1:0] REG_GRID_SIDE   = 2'd2;

  // Register reset values
  localparam logic [CCOUNT_W-1:0]   RESET_COLOR_COUNT = 5'd2;
  localparam logic [RULE_W-1:0]     RESET_TURN_RULES  = 30'd1;
  localparam logic [SIDE_CFG_W-1:0] RESET_GRID_SIDE   = 11'd700;

  // Grid memory request from the control side
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [COLOR_W-1:0] wr_data;
    logic              clear_start;
  } grid_req_t;

  // Outcome of one request
  typedef struct packed {
    logic [COORD_W-1:0] ant_x;
    logic [COORD_W-1:0] ant_y;
    logic [HEAD_W-1:0]  heading;
    logic [COLOR_W-1:0] cell_color;
    logic               halted;
    logic [COUNT_W-1:0] move_count;
    logic               wr_en;
    logic [COLOR_W-1:0] wr_data;
    logic               restart;
  } step_res_t;

endpackage

>>> rtl/multicolor_langton_ant_step_core.sv
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  command, read_x, read_y
// out_     output     out_valid/out_stall ant_x, ant_y, heading, cell_color, halted,
//                                        move_count
// cfg      APB        psel/penable/pready color_count @0, turn_rules @4, grid_side @8
//
// Each request reads the grid memory at the accept edge; the result is registered
// when the request completes, which waits while a stalled result is held, and the
// cell is written back at that edge; the next grid address depends on that update.
// After reset and after a restart request the whole grid is cleared one cell a cycle,
// with in_stall high; register writes are still taken.
// A stalled result holds the next request in the block, with in_stall high, until taken.
module multicolor_langton_ant_step_core import lant_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [READ_W-1:0]     in_read_x,
  input  logic [READ_W-1:0]     in_read_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_W-1:0]    out_ant_x,
  output logic [COORD_W-1:0]    out_ant_y,
  output logic [HEAD_W-1:0]     out_heading,
  output logic [COLOR_W-1:0]    out_cell_color,
  output logic                  out_halted,
  output logic [COUNT_W-1:0]    out_move_count,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t                state_r;
  logic [CCOUNT_W-1:0]   color_count_r;
  logic [RULE_W-1:0]     turn_rules_r;
  logic [SIDE_CFG_W-1:0] grid_side_r;
  logic [CMD_W-1:0]      cmd_r;
  logic [READ_W-1:0]     rx_r;
  logic [READ_W-1:0]     ry_r;
  logic [COORD_W-1:0]    pos_x_r;
  logic [COORD_W-1:0]    pos_y_r;
  logic [HEAD_W-1:0]     facing_r;
  logic [COUNT_W-1:0]    total_r;
  logic                  out_valid_r;
  logic [COORD_W-1:0]    out_x_r;
  logic [COORD_W-1:0]    out_y_r;
  logic [HEAD_W-1:0]     out_head_r;
  logic [COLOR_W-1:0]    out_color_r;
  logic                  out_halt_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic                  clearing;
  logic                  in_acc;
  logic                  done;
  logic [COLOR_W-1:0]    cell_rd;
  grid_req_t             greq;
  step_res_t             res;

  // Register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_count_r <= RESET_COLOR_COUNT;
      turn_rules_r  <= RESET_TURN_RULES;
      grid_side_r   <= RESET_GRID_SIDE;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_COLOR_COUNT: color_count_r <= pwdata[CCOUNT_W-1:0];
        REG_TURN_RULES:  turn_rules_r  <= pwdata[RULE_W-1:0];
        REG_GRID_SIDE:   grid_side_r   <= pwdata[SIDE_CFG_W-1:0];
        default:         color_count_r <= color_count_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COLOR_COUNT: prdata = {{(32 - CCOUNT_W){1'b0}}, color_count_r};
      REG_TURN_RULES:  prdata = {{(32 - RULE_W){1'b0}}, turn_rules_r};
      REG_GRID_SIDE:   prdata = {{(32 - SIDE_CFG_W){1'b0}}, grid_side_r};
      default:         prdata = '0;
    endcase
  end

  // Accept only when idle and the grid is not being cleared
  assign in_stall = (state_r != ST_IDLE) || clearing;
  assign in_acc   = in_valid && !in_stall;
  assign done     = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_command;
      rx_r  <= in_read_x;
      ry_r  <= in_read_y;
    end
  end

  // Grid access: read at accept, write back on completion
  always_comb begin
    greq         = '0;
    greq.rd_en   = in_acc;
    if (in_command == CMD_READ) begin
      greq.rd_addr = {in_read_y[SIDE_W-1:0], in_read_x[SIDE_W-1:0]};
    end else begin
      greq.rd_addr = {pos_y_r[SIDE_W-1:0], pos_x_r[SIDE_W-1:0]};
    end
    greq.wr_en       = done && res.wr_en;
    greq.wr_addr     = {pos_y_r[SIDE_W-1:0], pos_x_r[SIDE_W-1:0]};
    greq.wr_data     = res.wr_data;
    greq.clear_start = done && res.restart;
  end

  lant_grid u_grid (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (greq),
    .rd_data  (cell_rd),
    .clearing (clearing)
  );

  lant_step u_step (
    .cmd         (cmd_r),
    .read_x      (rx_r),
    .read_y      (ry_r),
    .pos_x       (pos_x_r),
    .pos_y       (pos_y_r),
    .facing      (facing_r),
    .total       (total_r),
    .color_count (color_count_r),
    .turn_rules  (turn_rules_r),
    .grid_side   (grid_side_r),
    .cell_in     (cell_rd),
    .res         (res)
  );

  // Sequencer, ant state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_x_r     <= RESET_GRID_SIDE >> 1;
      pos_y_r     <= RESET_GRID_SIDE >> 1;
      facing_r    <= HEAD_NORTH;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      out_x_r     <= '0;
      out_y_r     <= '0;
      out_head_r  <= '0;
      out_color_r <= '0;
      out_halt_r  <= 1'b0;
      out_count_r <= '0;
    end else begin
      // Drop the result once taken, unless a new one replaces it
      if (out_valid_r && !out_stall && !done) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (done) begin
            state_r     <= ST_IDLE;
            pos_x_r     <= res.ant_x;
            pos_y_r     <= res.ant_y;
            facing_r    <= res.heading;
            total_r     <= res.move_count;
            out_valid_r <= 1'b1;
            out_x_r     <= res.ant_x;
            out_y_r     <= res.ant_y;
            out_head_r  <= res.heading;
            out_color_r <= res.cell_color;
            out_halt_r  <= res.halted;
            out_count_r <= res.move_count;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ant_x      = out_x_r;
  assign out_ant_y      = out_y_r;
  assign out_heading    = out_head_r;
  assign out_cell_color = out_color_r;
  assign out_halted     = out_halt_r;
  assign out_move_count = out_count_r;

endmodule

>>> rtl/lant_grid.sv
module lant_grid import lant_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  grid_req_t          req,
  output logic [COLOR_W-1:0] rd_data,
  output logic               clearing
);

  logic [COLOR_W-1:0] mem [MEM_DEPTH];
  logic [COLOR_W-1:0] rd_data_r;
  logic               clearing_r;
  logic [ADDR_W-1:0]  clr_addr_r;

  // Sweep zeros through the grid, else take the update write; registered read
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // Clearing sweep after reset and on restart
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (req.clear_start) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == {ADDR_W{1'b1}}) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule

>>> rtl/lant_step.sv
module lant_step import lant_pkg::*; (
  input  logic [CMD_W-1:0]      cmd,
  input  logic [READ_W-1:0]     read_x,
  input  logic [READ_W-1:0]     read_y,
  input  logic [COORD_W-1:0]    pos_x,
  input  logic [COORD_W-1:0]    pos_y,
  input  logic [HEAD_W-1:0]     facing,
  input  logic [COUNT_W-1:0]    total,
  input  logic [CCOUNT_W-1:0]   color_count,
  input  logic [RULE_W-1:0]     turn_rules,
  input  logic [SIDE_CFG_W-1:0] grid_side,
  input  logic [COLOR_W-1:0]    cell_in,
  output step_res_t             res
);

  logic [COORD_W-1:0]  side;
  logic [CCOUNT_W-1:0] cnt;
  logic                cur_halt;
  logic [COLOR_W:0]    c_inc;
  logic [COLOR_W-1:0]  c_next;
  logic [31:0]         rules_ext;
  logic                right;
  logic [HEAD_W-1:0]   turned;
  logic [COORD_W-1:0]  nx;
  logic [COORD_W-1:0]  ny;
  logic                far_new;

  // Clamp the registers
  always_comb begin
    side = (grid_side > COORD_W'(MAX_SIDE)) ? COORD_W'(MAX_SIDE) : grid_side;
    if (color_count > CCOUNT_W'(MAX_COLORS)) begin
      cnt = CCOUNT_W'(MAX_COLORS);
    end else if (color_count == '0) begin
      cnt = CCOUNT_W'(1);
    end else begin
      cnt = color_count;
    end
  end

  // Cell color advance and turn direction
  always_comb begin
    cur_halt  = (pos_x == '0) || (pos_y == '0) || (pos_x >= side) || (pos_y >= side);
    c_inc     = {1'b0, cell_in} + 1'b1;
    c_next    = (c_inc < {1'b0, cnt}) ? c_inc[COLOR_W-1:0] : '0;
    rules_ext = {{(32 - RULE_W){1'b0}}, turn_rules};
    right     = rules_ext[cell_in];
    turned    = right ? facing + 1'b1 : facing - 1'b1;
  end

  // Next ant state and result fields
  always_comb begin
    res            = '0;
    res.ant_x      = pos_x;
    res.ant_y      = pos_y;
    res.heading    = facing;
    res.move_count = total;
    case (cmd)
      CMD_STEP: begin
        if (!cur_halt) begin
          res.heading    = turned;
          res.cell_color = c_next;
          res.wr_en      = 1'b1;
          res.wr_data    = c_next;
          case (turned)
            HEAD_NORTH: res.ant_y = pos_y - 1'b1;
            HEAD_EAST:  res.ant_x = pos_x + 1'b1;
            HEAD_SOUTH: res.ant_y = pos_y + 1'b1;
            HEAD_WEST:  res.ant_x = pos_x - 1'b1;
            default:    res.ant_x = pos_x;
          endcase
        end
      end
      CMD_READ: begin
        if ((COORD_W'(read_x) < side) && (COORD_W'(read_y) < side)) begin
          res.cell_color = cell_in;
        end
      end
      CMD_RESTART: begin
        res.ant_x      = side >> 1;
        res.ant_y      = side >> 1;
        res.heading    = HEAD_NORTH;
        res.move_count = '0;
        res.restart    = 1'b1;
      end
      default: begin
        res.cell_color = '0;
      end
    endcase
    nx      = res.ant_x;
    ny      = res.ant_y;
    far_new = (nx >= side) || (ny >= side);
    res.halted = (nx == '0) || (ny == '0) || far_new;
    // Count the step unless it ends on the far edge
    if ((cmd == CMD_STEP) && !far_new) begin
      res.move_count = total + 1'b1;
    end
  end

endmodule

>>> verif/tb_multicolor_langton_ant_step_core.sv
`timescale 1ns / 1ps

module tb_multicolor_langton_ant_step_core;
  import lant_pkg::*;

  // Command 3 has no meaning; the block reports state and changes nothing
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  // A grid clear sweeps all MEM_DEPTH cells with nothing moving
  localparam int IDLE_LIMIT     = 4_000_000;
  localparam int LONG_HOLD      = 400;
  localparam int PHASES         = 10;
  localparam int PHASE_REQUESTS = 150;
  localparam int HALTED_REQUESTS = 30;

  localparam logic [RULE_W-1:0]     ALL_RIGHT  = '1;
  localparam logic [SIDE_CFG_W-1:0] SIDE_WIDE  = 11'd2047;
  localparam logic [SIDE_CFG_W-1:0] SIDE_FULL  = 11'd1024;
  localparam logic [SIDE_CFG_W-1:0] SIDE_SMALL = 11'd100;
  localparam logic [SIDE_CFG_W-1:0] SIDE_TINY  = 11'd4;

  typedef struct packed {
    logic [COORD_W-1:0] ant_x;
    logic [COORD_W-1:0] ant_y;
    logic [HEAD_W-1:0]  heading;
    logic [COLOR_W-1:0] cell_color;
    logic               halted;
    logic [COUNT_W-1:0] move_count;
  } ant_view_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_command     = CMD_STEP;
  logic [READ_W-1:0]     in_read_x      = '0;
  logic [READ_W-1:0]     in_read_y      = '0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [COORD_W-1:0]    out_ant_x;
  logic [COORD_W-1:0]    out_ant_y;
  logic [HEAD_W-1:0]     out_heading;
  logic [COLOR_W-1:0]    out_cell_color;
  logic                  out_halted;
  logic [COUNT_W-1:0]    out_move_count;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [3:0]            paddr          = '0;
  logic [31:0]           pwdata         = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // Ant and grid as the block should hold them
  bit   [COLOR_W-1:0]    grid_colors [0:MEM_DEPTH-1];
  logic [COORD_W-1:0]    ant_col;
  logic [COORD_W-1:0]    ant_row;
  logic [HEAD_W-1:0]     ant_dir;
  logic [COUNT_W-1:0]    move_total;
  logic [CCOUNT_W-1:0]   cfg_colors;
  logic [RULE_W-1:0]     cfg_rules;
  logic [SIDE_CFG_W-1:0] cfg_side;

  ant_view_t             expected_views [$];
  ant_view_t             head_view;
  int unsigned           mismatch_count = 0;
  int unsigned           idle_cycles    = 0;

  // Sender and receiver pacing
  bit                    sender_gaps_on   = 1'b1;
  bit                    receiver_gaps_on = 1'b1;
  bit                    hold_req         = 1'b0;
  int unsigned           hold_left        = 0;
  int unsigned           burst_left       = 0;
  int unsigned           recv_roll;

  multicolor_langton_ant_step_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_read_x      (in_read_x),
    .in_read_y      (in_read_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ant_x      (out_ant_x),
    .out_ant_y      (out_ant_y),
    .out_heading    (out_heading),
    .out_cell_color (out_cell_color),
    .out_halted     (out_halted),
    .out_move_count (out_move_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned side_in_use();
    return (cfg_side > MAX_SIDE) ? MAX_SIDE : int'(cfg_side);
  endfunction

  function automatic bit on_far_edge(input int unsigned side);
    return (ant_col >= side) || (ant_row >= side);
  endfunction

  function automatic bit ant_halted(input int unsigned side);
    return (ant_col == 0) || (ant_row == 0) || on_far_edge(side);
  endfunction

  function automatic void restart_ant(input int unsigned side);
    for (int i = 0; i < MEM_DEPTH; i++) grid_colors[i] = '0;
    ant_col    = COORD_W'(side / 2);
    ant_row    = COORD_W'(side / 2);
    ant_dir    = HEAD_NORTH;
    move_total = '0;
  endfunction

  // Apply one request to the predicted ant and return what the block reports
  function automatic ant_view_t apply_request(input logic [CMD_W-1:0] cmd,
                                              input logic [READ_W-1:0] rx,
                                              input logic [READ_W-1:0] ry);
    int unsigned        side;
    int unsigned        cnt;
    int unsigned        idx;
    logic [COLOR_W-1:0] old_color;
    logic [COLOR_W-1:0] color;
    logic               turn_right;
    ant_view_t          view;

    side  = side_in_use();
    color = '0;
    case (cmd)
      CMD_STEP: begin
        if (!ant_halted(side)) begin
          cnt = (cfg_colors > MAX_COLORS) ? MAX_COLORS : int'(cfg_colors);
          if (cnt == 0) cnt = 1;
          idx        = int'(ant_row) * MAX_SIDE + int'(ant_col);
          old_color  = grid_colors[idx];
          color      = (old_color + 1 < cnt) ? COLOR_W'(old_color + 1) : '0;
          grid_colors[idx] = color;
          turn_right = (old_color < RULE_W) ? cfg_rules[old_color] : 1'b0;
          ant_dir    = turn_right ? ant_dir + 1'b1 : ant_dir - 1'b1;
          case (ant_dir)
            HEAD_NORTH: ant_row = ant_row - 1'b1;
            HEAD_EAST:  ant_col = ant_col + 1'b1;
            HEAD_SOUTH: ant_row = ant_row + 1'b1;
            default:    ant_col = ant_col - 1'b1;
          endcase
        end
        // Count keeps running on row or column 0, stops on the far edge
        if (!on_far_edge(side)) move_total = move_total + 1'b1;
      end
      CMD_READ: begin
        if (rx < side && ry < side) color = grid_colors[int'(ry) * MAX_SIDE + int'(rx)];
      end
      CMD_RESTART: begin
        restart_ant(side);
      end
      default: ;
    endcase

    view.ant_x      = ant_col;
    view.ant_y      = ant_row;
    view.heading    = ant_dir;
    view.cell_color = color;
    view.halted     = ant_halted(side);
    view.move_count = move_total;
    return view;
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic int unsigned pick_pause(input bit enabled);
    int unsigned roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [READ_W-1:0] rx,
                              input logic [READ_W-1:0] ry);
    int unsigned pause;
    pause = pick_pause(sender_gaps_on);
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_read_x  <= rx;
    in_read_y  <= ry;
    do @(posedge clk); while (in_stall);
    expected_views.push_back(apply_request(cmd, rx, ry));
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_views.size() != 0);
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_COLOR_COUNT: cfg_colors = value[CCOUNT_W-1:0];
      REG_TURN_RULES:  cfg_rules  = value[RULE_W-1:0];
      REG_GRID_SIDE:   cfg_side   = value[SIDE_CFG_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- receiver

  // Pace out_stall: random bursts, or a long hold when the test asks
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!receiver_gaps_on) begin
      out_stall <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      recv_roll = $urandom_range(0, 99);
      if (recv_roll < 55) begin
        out_stall  <= 1'b0;
        burst_left = $urandom_range(0, 12);
      end else if (recv_roll < 92) begin
        out_stall  <= 1'b1;
        burst_left = $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        burst_left = $urandom_range(10, 50);
      end
    end
  end

  task automatic compare_field(input string label, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // Check each taken result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_views.size() == 0) begin
        $display("%0t result with no request outstanding: x %0d y %0d", $time,
                 out_ant_x, out_ant_y);
        mismatch_count++;
      end else begin
        head_view = expected_views.pop_front();
        compare_field("ant_x", head_view.ant_x, out_ant_x);
        compare_field("ant_y", head_view.ant_y, out_ant_y);
        compare_field("heading", head_view.heading, out_heading);
        compare_field("cell_color", head_view.cell_color, out_cell_color);
        compare_field("halted", head_view.halted, out_halted);
        compare_field("move_count", head_view.move_count, out_move_count);
      end
    end
  end

  // End the run if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no request moved for %0d cycles", $time, idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // Reads and an unused command on the freshly cleared grid
  task automatic test_idle_grid();
    send_request(CMD_READ, 10'd350, 10'd350);
    send_request(CMD_READ, 10'd1023, 10'd0);
    send_request(CMD_NONE, 10'h3FF, 10'h3FF);
  endtask

  // A few steps under the reset rule, then read the cell left behind
  task automatic test_classic_walk();
    repeat (3) send_request(CMD_STEP, '0, '0);
    send_request(CMD_READ, 10'd350, 10'd350);
  endtask

  // Color count of zero, above the maximum and at the maximum; rule extremes
  task automatic test_color_extremes();
    write_reg(REG_COLOR_COUNT, 32'd0);
    send_request(CMD_STEP, '0, '0);
    write_reg(REG_COLOR_COUNT, 32'd31);
    write_reg(REG_TURN_RULES, 32'(ALL_RIGHT));
    send_request(CMD_STEP, '0, '0);
    write_reg(REG_COLOR_COUNT, 32'(MAX_COLORS));
    write_reg(REG_TURN_RULES, 32'd0);
    send_request(CMD_STEP, '0, '0);
  endtask

  // Grid shrunk under the ant, halt on column 0, zero side, wide restart
  task automatic test_edge_halts();
    write_reg(REG_GRID_SIDE, 32'(SIDE_SMALL));
    send_request(CMD_STEP, '0, '0);
    send_request(CMD_READ, 10'd50, 10'd50);
    write_reg(REG_GRID_SIDE, 32'(SIDE_TINY));
    write_reg(REG_COLOR_COUNT, 32'(RESET_COLOR_COUNT));
    write_reg(REG_TURN_RULES, 32'(RESET_TURN_RULES));
    send_request(CMD_RESTART, '0, '0);
    // The classic ant leaves a side-4 grid through column 0 within a dozen steps
    repeat (12) send_request(CMD_STEP, '0, '0);
    write_reg(REG_GRID_SIDE, 32'd0);
    send_request(CMD_STEP, '0, '0);
    write_reg(REG_GRID_SIDE, 32'(SIDE_WIDE));
    send_request(CMD_RESTART, '0, '0);
  endtask

  // Phases of random walking, each under a fresh setting of the registers
  task automatic test_random_walk();
    int unsigned           roll;
    int unsigned           reach;
    int unsigned           requests;
    logic [CCOUNT_W-1:0]   colors_pick;
    logic [RULE_W-1:0]     rules_pick;
    logic [SIDE_CFG_W-1:0] side_pick;

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       colors_pick = RESET_COLOR_COUNT;
        1:       colors_pick = CCOUNT_W'(MAX_COLORS);
        2:       colors_pick = 5'd31;
        3:       colors_pick = 5'd3;
        default: colors_pick = CCOUNT_W'($urandom_range(2, MAX_COLORS));
      endcase
      if (phase == 0) rules_pick = RESET_TURN_RULES;
      else if (phase == 1) rules_pick = ALL_RIGHT;
      else rules_pick = RULE_W'($urandom);

      // Place the far edge just beyond the ant in some phases
      reach = (ant_col > ant_row) ? ant_col : ant_row;
      case (phase % 5)
        0:       side_pick = SIDE_WIDE;
        2:       side_pick = SIDE_FULL;
        3:       side_pick = SIDE_SMALL;
        default: side_pick = SIDE_CFG_W'(reach + $urandom_range(1, 12));
      endcase
      requests = (phase % 5 == 3) ? HALTED_REQUESTS : PHASE_REQUESTS;

      write_reg(REG_COLOR_COUNT, 32'(colors_pick));
      write_reg(REG_TURN_RULES, 32'(rules_pick));
      write_reg(REG_GRID_SIDE, 32'(side_pick));

      sender_gaps_on   = !(phase == 2 || phase == 5);
      receiver_gaps_on = (phase != 5);
      // Stall the results for a long stretch while requests keep coming
      if (phase == 2) hold_req = 1'b1;

      repeat (requests) begin
        roll = $urandom_range(0, 99);
        if (roll < 82) begin
          send_request(CMD_STEP, READ_W'($urandom), READ_W'($urandom));
        end else if (roll < 90) begin
          send_request(CMD_READ, READ_W'(ant_col + $urandom_range(0, 4) - 2),
                       READ_W'(ant_row + $urandom_range(0, 4) - 2));
        end else if (roll < 97) begin
          send_request(CMD_READ, READ_W'($urandom), READ_W'($urandom));
        end else begin
          send_request(CMD_NONE, READ_W'($urandom), READ_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    cfg_colors = RESET_COLOR_COUNT;
    cfg_rules  = RESET_TURN_RULES;
    cfg_side   = RESET_GRID_SIDE;
    restart_ant(side_in_use());

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_grid();
    test_classic_walk();
    test_color_extremes();
    test_edge_halts();
    test_random_walk();

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_views.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
